// ===== rtl/max_heap_priority_queue_macros.svh =====
// Assertion macros for the max-heap priority queue.
`ifndef MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

`define MHPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("max_heap_priority_queue: same-cycle check failed");

`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("max_heap_priority_queue: next-cycle check failed");

`else

`define MHPQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/mhpq_pkg.sv =====
// Shared types and codes for the max-heap priority queue.
package mhpq_pkg;

  localparam int DATA_W = 32;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_OVERFLOW  = 2'd1;
  localparam status_t STATUS_UNDERFLOW = 2'd2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

endpackage

// ===== rtl/mhpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/max_heap_priority_queue.sv =====
// Top level of the max-heap priority queue: control, count and two mirrored heap RAMs.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready   | in_cmd, in_value
//  out     | output    | out_valid/out_ready | out_status, out_top_value, out_count
//
// An item that walks no level (insert into an empty heap, overflow, underflow, remove of the
// last element) goes from ST_IDLE straight to ST_FIN; in_ready stays low until it is done.
// An insert climbs in ST_UP, one level per compare, then writes its value in ST_PUT; a remove
// reads the last element in ST_DN_LAST, sinks it in ST_DN while it has a child, one level per
// compare, then writes it in ST_PUT. ST_FIN loads the result into the output register.
// Reset clears the count and control; heap RAM contents need no clearing.
// A new item is taken while the previous result still waits in the output register;
// a finished item waits in its last state until that register frees up.
`include "max_heap_priority_queue_macros.svh"

module max_heap_priority_queue #(
  parameter int CAPACITY = 127
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_cmd,
  input  logic signed [31:0]      in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output mhpq_pkg::status_t       out_status,
  output logic signed [31:0]      out_top_value,
  output logic [6:0]              out_count
);

  import mhpq_pkg::*;

  localparam int DEPTH = CAPACITY + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = AW + 1;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_UP      = 3'd1;
  localparam logic [2:0] ST_DN_LAST = 3'd2;
  localparam logic [2:0] ST_DN      = 3'd3;
  localparam logic [2:0] ST_PUT     = 3'd4;
  localparam logic [2:0] ST_FIN     = 3'd5;

  logic [2:0]               state_r, state_nxt;
  logic [AW-1:0]            count_r, count_nxt;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic signed [DATA_W-1:0] v_r, v_nxt;
  logic signed [DATA_W-1:0] top_r, top_nxt;
  status_t                  status_r, status_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic signed [DATA_W-1:0] out_top_r, out_top_nxt;
  logic [6:0]               out_count_r, out_count_nxt;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic [AW-1:0]            raddr_a, raddr_b;
  logic [DATA_W-1:0]        rdata_a, rdata_b;
  logic signed [DATA_W-1:0] rd_a, rd_b;

  logic [PW-1:0]            left_w, right_w, n_ext, best_left;
  logic [AW-1:0]            best;
  logic signed [DATA_W-1:0] best_dat, rcmp;
  logic                     lbig, rbig;
  logic [AW-1:0]            par;

  mhpq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mhpq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  assign rd_a = $signed(rdata_a);
  assign rd_b = $signed(rdata_b);

  assign left_w  = {pos_r, 1'b0};
  assign right_w = left_w + PW'(1);
  assign n_ext   = {1'b0, count_r};
  assign par     = pos_r >> 1;

  assign lbig     = rd_a > v_r;
  assign rcmp     = lbig ? rd_a : v_r;
  assign rbig     = (right_w <= n_ext) && (rd_b > rcmp);
  assign best     = rbig ? AW'(right_w) : AW'(left_w);
  assign best_dat = rbig ? rd_b : rd_a;
  assign best_left = {best, 1'b0};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    v_nxt          = v_r;
    top_nxt        = top_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_top_nxt    = out_top_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = v_r;
    raddr_a        = '0;
    raddr_b        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          status_nxt = STATUS_OK;
          if (in_cmd == CMD_INSERT) begin
            if (count_r == AW'(CAPACITY)) begin
              status_nxt = STATUS_OVERFLOW;
              state_nxt  = ST_FIN;
            end else begin
              count_nxt = count_r + AW'(1);
              v_nxt     = in_value;
              pos_nxt   = count_r + AW'(1);
              if (count_r == '0) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(1);
                ram_wdata = in_value;
                top_nxt   = in_value;
                state_nxt = ST_FIN;
              end else begin
                raddr_a   = (count_r + AW'(1)) >> 1;
                state_nxt = ST_UP;
              end
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = STATUS_UNDERFLOW;
              state_nxt  = ST_FIN;
            end else begin
              raddr_a   = count_r;
              count_nxt = count_r - AW'(1);
              pos_nxt   = AW'(1);
              state_nxt = (count_r == AW'(1)) ? ST_FIN : ST_DN_LAST;
            end
          end
        end
      end
      ST_UP: begin
        if (v_r > rd_a) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = rd_a;
          pos_nxt   = par;
          if (par == AW'(1)) begin
            state_nxt = ST_PUT;
          end else begin
            raddr_a = par >> 1;
          end
        end else begin
          state_nxt = ST_PUT;
        end
      end
      ST_DN_LAST: begin
        v_nxt = rd_a;
        if (left_w <= n_ext) begin
          raddr_a   = AW'(left_w);
          raddr_b   = AW'(right_w);
          state_nxt = ST_DN;
        end else begin
          state_nxt = ST_PUT;
        end
      end
      ST_DN: begin
        if (lbig || rbig) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = best_dat;
          if (pos_r == AW'(1)) begin
            top_nxt = best_dat;
          end
          pos_nxt = best;
          if (best_left <= n_ext) begin
            raddr_a = AW'(best_left);
            raddr_b = AW'(best_left + PW'(1));
          end else begin
            state_nxt = ST_PUT;
          end
        end else begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = v_r;
        if (pos_r == AW'(1)) begin
          top_nxt = v_r;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_top_nxt    = (count_r == '0) ? '0 : top_r;
          out_count_nxt  = 7'(count_r);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    v_r          <= v_nxt;
    top_r        <= top_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_top_r    <= out_top_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_top_value = out_top_r;
  assign out_count     = out_count_r;

  `MHPQ_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= AW'(CAPACITY))
  `MHPQ_ASSERT_NEXT(a_count_step, clk, rst_n, state_r == ST_IDLE && in_valid,
    count_r == $past(count_r) || count_r == $past(count_r) + AW'(1) ||
    count_r == $past(count_r) - AW'(1))
  `MHPQ_ASSERT_NEXT(a_hold_count, clk, rst_n, state_r != ST_IDLE && state_r != ST_FIN,
    $stable(count_r))
  `MHPQ_ASSERT_SAME(a_empty_top, clk, rst_n, out_valid_r && out_status_r == STATUS_UNDERFLOW,
    out_top_r == '0 && out_count_r == 7'd0)

endmodule

// ===== tb/sv/max_heap_priority_queue_tb.sv =====
// Self-checking testbench for the max-heap priority queue: random commands vs. a heap predictor.
`timescale 1ns/1ps
module max_heap_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mhpq_pkg::*;

  localparam int HEAP_CAP    = 127;
  localparam int NUM_ITEMS   = 1450;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 500;

  typedef struct {
    logic               cmd;
    logic signed [31:0] value;
    bit                 drain;
  } heap_cmd_t;

  typedef struct {
    status_t            status;
    logic signed [31:0] top;
    logic [6:0]         cnt;
  } heap_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_cmd = CMD_INSERT;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  status_t            out_status;
  logic signed [31:0] out_top_value;
  logic [6:0]         out_count;

  heap_cmd_t          cmd_q[$];
  heap_result_t       expected_q[$];
  logic signed [31:0] heap_mem [1:HEAP_CAP];
  int                 heap_len = 0;
  int                 gen_len = 0;
  int                 errors = 0;
  int                 beats_in = 0;
  int                 cycle_cnt = 0;
  bit                 in_taken = 1'b0;
  int                 tx_gap = 0;
  int                 rx_gap = 0;
  int                 hold_left = 0;
  bit                 hold_done = 1'b0;
  logic               rx_hold = 1'b0;

  max_heap_priority_queue #(.CAPACITY(HEAP_CAP)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_top_value(out_top_value),
    .out_count    (out_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((cycle_cnt % 500) < 100) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic signed [31:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return $signed($urandom_range(0, 8)) - 4;
    if (r < 30) begin
      case ($urandom_range(0, 5))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0000_0000;
        3: return -32'sd1;
        4: return 32'sh8000_0001;
        default: return 32'sh7fff_fffe;
      endcase
    end
    return $urandom;
  endfunction

  function automatic void push_cmd(logic cmd, logic signed [31:0] value, bit drain);
    heap_cmd_t c;
    c.cmd = cmd;
    c.value = value;
    c.drain = drain;
    cmd_q = {cmd_q, c};
    if (cmd == CMD_INSERT) begin
      if (gen_len < HEAP_CAP) gen_len++;
    end else if (gen_len > 0) begin
      gen_len--;
    end
  endfunction

  // Predict one command and queue its result.
  function automatic void predict_result(logic cmd, logic signed [31:0] value);
    heap_result_t       r;
    int                 pos, par, left, right, best;
    bit                 done;
    logic signed [31:0] t;
    r.status = STATUS_OK;
    if (cmd == CMD_INSERT) begin
      if (heap_len >= HEAP_CAP) begin
        r.status = STATUS_OVERFLOW;
      end else begin
        heap_len++;
        heap_mem[heap_len] = value;
        pos = heap_len;
        done = 1'b0;
        while (pos > 1 && !done) begin
          par = pos / 2;
          if (heap_mem[pos] > heap_mem[par]) begin
            t = heap_mem[pos];
            heap_mem[pos] = heap_mem[par];
            heap_mem[par] = t;
            pos = par;
          end else begin
            done = 1'b1;
          end
        end
      end
    end else begin
      if (heap_len == 0) begin
        r.status = STATUS_UNDERFLOW;
      end else begin
        heap_mem[1] = heap_mem[heap_len];
        heap_len--;
        pos = 1;
        done = 1'b0;
        while (!done) begin
          left = 2 * pos;
          right = left + 1;
          best = pos;
          if (left <= heap_len && heap_mem[left] > heap_mem[best]) best = left;
          if (right <= heap_len && heap_mem[right] > heap_mem[best]) best = right;
          if (best == pos) begin
            done = 1'b1;
          end else begin
            t = heap_mem[pos];
            heap_mem[pos] = heap_mem[best];
            heap_mem[best] = t;
            pos = best;
          end
        end
      end
    end
    r.top = (heap_len > 0) ? heap_mem[1] : '0;
    r.cnt = heap_len[6:0];
    expected_q = {expected_q, r};
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predict_result(in_cmd, in_value);
      beats_in++;
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : driver
    logic      nv;
    heap_cmd_t c;
    nv = 1'b0;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (in_valid && !in_taken) begin
      nv = 1'b1;
    end else begin
      in_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (cmd_q.size() != 0 && !(cmd_q[0].drain && expected_q.size() != 0)) begin
        c = cmd_q.pop_front();
        in_cmd <= c.cmd;
        in_value <= c.value;
        nv = 1'b1;
        tx_gap = pick_gap();
      end
    end
    in_valid <= nv;
  end

  always @(negedge clk) begin : hold_ctrl
    if (!hold_done && beats_in >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) hold_left--;
    rx_hold <= (hold_left > 0);
  end

  always @(negedge clk) begin : sink
    logic nr;
    if (!rst_n || rx_hold) begin
      nr = 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      nr = 1'b0;
    end else begin
      nr = 1'b1;
      if ($urandom_range(0, 3) == 0) rx_gap = pick_gap();
    end
    out_ready <= nr;
  end

  always @(posedge clk) begin : monitor
    heap_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat status=%0d top=%0d count=%0d", $time,
                 out_status, out_top_value, out_count);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
          errors++;
        end
        if (out_top_value !== e.top) begin
          $display("%0t: top_value expected %0d actual %0d", $time, e.top, out_top_value);
          errors++;
        end
        if (out_count !== e.cnt) begin
          $display("%0t: count expected %0d actual %0d", $time, e.cnt, out_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int kind;
    int n;
    int ins_pct;
    bit first;
    push_cmd(CMD_REMOVE, rand_value(), 1'b0);
    push_cmd(CMD_INSERT, 32'sh0000_0000, 1'b0);
    push_cmd(CMD_INSERT, 32'sh8000_0000, 1'b0);
    push_cmd(CMD_INSERT, 32'sh7fff_ffff, 1'b0);
    push_cmd(CMD_INSERT, -32'sd1, 1'b0);
    push_cmd(CMD_INSERT, 32'sd7, 1'b0);
    push_cmd(CMD_INSERT, 32'sd7, 1'b0);
    push_cmd(CMD_INSERT, 32'sd5, 1'b0);
    push_cmd(CMD_INSERT, 32'sd5, 1'b0);
    repeat (3) push_cmd(CMD_REMOVE, rand_value(), 1'b0);
    push_cmd(CMD_INSERT, 32'sd7, 1'b0);
    repeat (7) push_cmd(CMD_REMOVE, 32'shffff_ffff, 1'b0);

    first = 1'b1;
    while (cmd_q.size() < NUM_ITEMS) begin
      kind = $urandom_range(0, 2);
      push_cmd(($urandom_range(0, 1) == 1) ? CMD_REMOVE : CMD_INSERT, rand_value(),
               first || ($urandom_range(0, 3) == 0));
      first = 1'b0;
      if (kind == 0) begin
        while (gen_len < HEAP_CAP && cmd_q.size() < NUM_ITEMS)
          push_cmd(($urandom_range(0, 99) < 80) ? CMD_INSERT : CMD_REMOVE, rand_value(), 1'b0);
        repeat ($urandom_range(1, 4)) push_cmd(CMD_INSERT, rand_value(), 1'b0);
      end else if (kind == 1) begin
        while (gen_len > 0 && cmd_q.size() < NUM_ITEMS)
          push_cmd(($urandom_range(0, 99) < 80) ? CMD_REMOVE : CMD_INSERT, rand_value(), 1'b0);
        repeat ($urandom_range(1, 3)) push_cmd(CMD_REMOVE, rand_value(), 1'b0);
      end else begin
        n = $urandom_range(30, 100);
        ins_pct = $urandom_range(30, 70);
        repeat (n)
          push_cmd(($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_REMOVE,
                   rand_value(), 1'b0);
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    while (cmd_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (expected_q.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, expected_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
